/* rtl/tsp_pkg.sv */
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants for timed step playback
// Holds the step table sizes, the item structs, the mode and status codes,
// the controller states and the command/status bundles between the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

  // Table sizes
  localparam int STEPS      = 128;
  localparam int TEXT_BYTES = 64;
  localparam int STEP_TEXT  = TEXT_BYTES - 1;

  // Derived widths
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;   // step index
  localparam int CNT_W  = $clog2(STEPS + 1);                 // step count
  localparam int IDX_W  = $clog2(TEXT_BYTES);                // byte index / length
  localparam int ADDR_W = STEP_W + IDX_W;                    // text store address

  // Fixed field widths
  localparam int TIME_W        = 48;
  localparam int DELAY_W       = 16;
  localparam int STEP_COUNT_W  = 8;

  // Input modes
  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_RECORD = 3'd1,
    MODE_START  = 3'd2,
    MODE_TICK   = 3'd3,
    MODE_STOP   = 3'd4
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_WAITING  = 2'd1,
    ST_REJECTED = 2'd2,
    ST_EMIT     = 2'd3
  } status_t;

  // Input beat
  typedef struct packed {
    logic [2:0]         mode;
    logic [7:0]         data_byte;
    logic               end_of_step;
    logic [DELAY_W-1:0] pause_ms;
    logic               loop_enable;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [1:0]              status;
    logic [7:0]              out_byte;
    logic                    byte_valid;
    logic                    last;
    logic                    playing;
    logic [STEP_COUNT_W-1:0] step_count;
  } out_item_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_LOOKUP,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic decode;
    logic lookup;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tick_hit;
    logic len_zero;
    logic emit_last;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/timed_step_playback.sv */
// ----------------------------------------------------------------------------
// timed_step_playback: record and timed replay of text steps
// Top level joining the sequencing controller and the step table datapath.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; busy stays high until
// the beat's work is done. Clear, record, start, stop, rejected or early ticks
// pass through decode and give one result. A due tick passes through decode
// and lookup, then gives one result per stored byte of the step (up to 63),
// since the single read port of the text store delivers one byte per cycle;
// an empty step gives one result. Each result appears on out_item for exactly
// one cycle with out_strobe high, in the cycle after it is formed; the receiver
// cannot stall, so it must take every strobed beat. The next beat may be given
// while the last result of the previous one is still on the result ports.
`timescale 1ns / 1ps
`default_nettype none

module timed_step_playback (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire tsp_pkg::in_item_t  in_item,
  output logic                    out_strobe,
  output tsp_pkg::out_item_t      out_item
);

  import tsp_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencing
  tsp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Table and playback state
  tsp_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

/* rtl/tsp_ctrl.sv */
// ----------------------------------------------------------------------------
// tsp_ctrl: sequencing controller for timed step playback
// Walks each accepted beat through decode and, for a due tick, table lookup and byte emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire tsp_pkg::dp_stat_t stat,
  output tsp_pkg::ctrl_cmd_t     cmd,
  output logic                   busy
);

  import tsp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = stat.tick_hit ? S_LOOKUP : S_IDLE;
      end
      S_LOOKUP: begin
        state_nxt = stat.len_zero ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (stat.emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Lookup only follows a decode that hit
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOKUP |-> $past(state_r) == S_DECODE && $past(stat.tick_hit))
    else $error("lookup entered without a due tick");

  // Emission only follows lookup or emission
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> $past(state_r) == S_LOOKUP || $past(state_r) == S_EMIT)
    else $error("emit entered from wrong state");

endmodule

`default_nettype wire

/* rtl/tsp_datapath.sv */
// ----------------------------------------------------------------------------
// tsp_datapath: step table, playback registers and result register
// Stores step text, lengths and delays in memories, applies each decoded beat
// to the playback state, and streams a step's bytes one per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsp_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tsp_pkg::in_item_t   in_item,
  input  wire tsp_pkg::ctrl_cmd_t  cmd,
  output tsp_pkg::dp_stat_t        stat,
  output logic                     out_strobe,
  output tsp_pkg::out_item_t       out_item
);

  import tsp_pkg::*;

  // Step table memories
  logic [7:0]         text_mem [2**ADDR_W];
  logic [IDX_W-1:0]   len_mem  [2**STEP_W];
  logic [DELAY_W-1:0] dly_mem  [2**STEP_W];

  // Captured beat
  in_item_t in_r;

  // Playback state
  logic [CNT_W-1:0]  steps_r,   steps_nxt;
  logic [IDX_W-1:0]  pend_r,    pend_nxt;
  logic [STEP_W-1:0] cursor_r,  cursor_nxt;
  logic              loop_r,    loop_nxt;
  logic              playing_r, playing_nxt;
  logic [TIME_W-1:0] due_r,     due_nxt;

  // Emission working registers
  logic [STEP_W-1:0]  cur_r,     cur_nxt;
  logic               upd_due_r, upd_due_nxt;
  logic [IDX_W-1:0]   len_r,     len_nxt;
  logic [IDX_W-1:0]   idx_r,     idx_nxt;
  logic [IDX_W-1:0]   len_rd_r;
  logic [DELAY_W-1:0] dly_rd_r;
  logic [7:0]         text_rd_r;

  // Result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r,       out_nxt;

  // Decode helpers
  logic              rec_ok;
  logic              store_byte;
  logic [IDX_W-1:0]  pend_inc;
  logic [CNT_W-1:0]  cur_inc;
  logic              wrap;
  logic              tick_ok;
  logic              tick_due;
  logic              tick_hit;
  logic [IDX_W-1:0]  idx_inc;
  status_t           status;

  // Memory ports
  logic              text_we;
  logic              meta_we;
  logic [ADDR_W-1:0] text_waddr;
  logic [ADDR_W-1:0] text_raddr;
  logic [STEP_W-1:0] dly_raddr;
  logic [STEP_W-1:0] wr_step;

  // Decode conditions
  assign rec_ok     = steps_r < CNT_W'(STEPS);
  assign store_byte = (in_r.data_byte != 8'd0) && (pend_r < IDX_W'(STEP_TEXT));
  assign pend_inc   = pend_r + IDX_W'(1);
  assign cur_inc    = CNT_W'(cursor_r) + CNT_W'(1);
  assign wrap       = cur_inc >= steps_r;
  assign tick_ok    = playing_r && (CNT_W'(cursor_r) < steps_r);
  assign tick_due   = in_r.now_ms >= due_r;
  assign tick_hit   = (in_r.mode == MODE_TICK) && tick_ok && tick_due;
  assign idx_inc    = idx_r + IDX_W'(1);
  assign wr_step    = steps_r[STEP_W-1:0];

  // Memory addressing
  assign text_waddr = {wr_step, pend_r};
  assign text_raddr = cmd.lookup ? {cur_r, IDX_W'(0)} : {cur_r, idx_inc};
  assign dly_raddr  = wrap ? cursor_r : cur_inc[STEP_W-1:0];

  // Status to controller
  assign stat.tick_hit  = tick_hit;
  assign stat.len_zero  = (len_rd_r == '0);
  assign stat.emit_last = (idx_inc == len_r);

  // Apply commands
  always_comb begin
    steps_nxt     = steps_r;
    pend_nxt      = pend_r;
    cursor_nxt    = cursor_r;
    loop_nxt      = loop_r;
    playing_nxt   = playing_r;
    due_nxt       = due_r;
    cur_nxt       = cur_r;
    upd_due_nxt   = upd_due_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    text_we       = 1'b0;
    meta_we       = 1'b0;
    out_valid_nxt = 1'b0;
    status        = ST_ACCEPTED;
    out_nxt       = '0;

    if (cmd.decode) begin
      case (mode_t'(in_r.mode))
        MODE_CLEAR: begin
          steps_nxt   = '0;
          pend_nxt    = '0;
          cursor_nxt  = '0;
          loop_nxt    = 1'b0;
          playing_nxt = 1'b0;
          due_nxt     = '0;
        end
        MODE_RECORD: begin
          if (!rec_ok) begin
            status = ST_REJECTED;
          end else begin
            text_we = store_byte;
            if (store_byte) begin
              pend_nxt = pend_inc;
            end
            if (in_r.end_of_step) begin
              meta_we   = 1'b1;
              steps_nxt = steps_r + CNT_W'(1);
              pend_nxt  = '0;
            end
          end
        end
        MODE_START: begin
          if (steps_r == '0) begin
            status = ST_REJECTED;
          end else begin
            cursor_nxt  = '0;
            loop_nxt    = in_r.loop_enable;
            playing_nxt = 1'b1;
            due_nxt     = in_r.now_ms;
          end
        end
        MODE_TICK: begin
          if (!tick_ok) begin
            status = ST_REJECTED;
          end else if (!tick_due) begin
            status = ST_WAITING;
          end else begin
            // advance the cursor; delay is fetched for the lookup cycle
            cur_nxt     = cursor_r;
            upd_due_nxt = !wrap || loop_r;
            if (!wrap) begin
              cursor_nxt = cur_inc[STEP_W-1:0];
            end else if (loop_r) begin
              cursor_nxt = '0;
            end else begin
              playing_nxt = 1'b0;
            end
          end
        end
        MODE_STOP: begin
          playing_nxt = 1'b0;
        end
        default: begin
          status = ST_REJECTED;
        end
      endcase
      out_valid_nxt      = !tick_hit;
      out_nxt.status     = status;
      out_nxt.last       = 1'b1;
      out_nxt.playing    = playing_nxt;
      out_nxt.step_count = STEP_COUNT_W'(steps_nxt);
    end else if (cmd.lookup) begin
      // schedule the next step and open the byte walk
      if (upd_due_r) begin
        due_nxt = in_r.now_ms + TIME_W'(dly_rd_r);
      end
      len_nxt            = len_rd_r;
      idx_nxt            = '0;
      out_valid_nxt      = (len_rd_r == '0);
      out_nxt.status     = ST_EMIT;
      out_nxt.last       = 1'b1;
      out_nxt.playing    = playing_r;
      out_nxt.step_count = STEP_COUNT_W'(steps_r);
    end else if (cmd.emit) begin
      // one stored byte per cycle
      idx_nxt            = idx_inc;
      out_valid_nxt      = 1'b1;
      out_nxt.status     = ST_EMIT;
      out_nxt.out_byte   = text_rd_r;
      out_nxt.byte_valid = 1'b1;
      out_nxt.last       = (idx_inc == len_r);
      out_nxt.playing    = playing_r;
      out_nxt.step_count = STEP_COUNT_W'(steps_r);
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r     <= '0;
      pend_r      <= '0;
      cursor_r    <= '0;
      loop_r      <= 1'b0;
      playing_r   <= 1'b0;
      due_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      steps_r     <= steps_nxt;
      pend_r      <= pend_nxt;
      cursor_r    <= cursor_nxt;
      loop_r      <= loop_nxt;
      playing_r   <= playing_nxt;
      due_r       <= due_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_item;
    end
    cur_r     <= cur_nxt;
    upd_due_r <= upd_due_nxt;
    len_r     <= len_nxt;
    idx_r     <= idx_nxt;
    out_r     <= out_nxt;
  end

  // Text store
  always_ff @(posedge clk) begin
    if (text_we) begin
      text_mem[text_waddr] <= in_r.data_byte;
    end
    text_rd_r <= text_mem[text_raddr];
  end

  // Length and delay stores
  always_ff @(posedge clk) begin
    if (meta_we) begin
      len_mem[wr_step] <= pend_nxt == '0 && store_byte ? pend_inc : pend_r + IDX_W'(store_byte);
      dly_mem[wr_step] <= in_r.pause_ms;
    end
    len_rd_r <= len_mem[cursor_r];
    dly_rd_r <= dly_mem[dly_raddr];
  end

  assign out_strobe = out_valid_r;
  assign out_item   = out_r;

  // Pending length never exceeds a step's capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= IDX_W'(STEP_TEXT))
    else $error("pending length overflow");

  // Step count never exceeds the table
  assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= CNT_W'(STEPS))
    else $error("step count overflow");

  // Byte walk stays inside the step length
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> idx_r < len_r)
    else $error("byte walk past step length");

  // A decode that does not start emission leaves exactly one result
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decode && !tick_hit |=> out_valid_r && out_r.last)
    else $error("missing single result after decode");

endmodule

`default_nettype wire

/* tb/sv/timed_step_playback_checker.sv */
// ----------------------------------------------------------------------------
// timed_step_playback_checker: result prediction and comparison
// Watches the command and result channels of timed_step_playback, keeps its
// own step table, works out the result beats of every accepted command and
// compares each strobed result beat, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_step_playback_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire tsp_pkg::in_item_t  in_item,
  input  wire logic               out_strobe,
  input  wire tsp_pkg::out_item_t out_item,
  output int                      fail_count,
  output int                      open_count
);

  import tsp_pkg::*;

  // Step table as the block should hold it
  logic [7:0]              text_mem  [STEPS][STEP_TEXT];
  logic [IDX_W-1:0]        text_len  [STEPS];
  logic [DELAY_W-1:0]      delay_mem [STEPS];
  logic [STEP_COUNT_W-1:0] n_steps;
  logic [IDX_W-1:0]        pend_len;
  logic [STEP_COUNT_W-1:0] cursor;
  logic                    loop_on;
  logic                    playing;
  logic [TIME_W-1:0]       due_ms;

  // Result beats still to come, oldest first
  out_item_t answer_q[$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
  endtask

  // Text and lengths stay as they are: no step is read before it is written
  function automatic void clear_table();
    n_steps  = '0;
    pend_len = '0;
    cursor   = '0;
    loop_on  = 1'b0;
    playing  = 1'b0;
    due_ms   = '0;
  endfunction

  function automatic void push_answer(status_t st, logic [7:0] b, logic v, logic l);
    out_item_t a;
    a.status     = st;
    a.out_byte   = b;
    a.byte_valid = v;
    a.last       = l;
    a.playing    = playing;
    a.step_count = n_steps;
    answer_q.push_back(a);
  endfunction

  // Apply one command to the table and queue the beats it gives
  task automatic run_command(input in_item_t it);
    logic [STEP_W-1:0] cur;
    logic [IDX_W-1:0]  len;
    case (it.mode)
      MODE_CLEAR: begin
        clear_table();
        push_answer(ST_ACCEPTED, 8'h00, 1'b0, 1'b1);
      end
      MODE_RECORD: begin
        if (n_steps >= STEPS) begin
          push_answer(ST_REJECTED, 8'h00, 1'b0, 1'b1);
        end else begin
          // zero bytes and bytes past the step limit are dropped
          if (it.data_byte != 8'h00 && pend_len < STEP_TEXT) begin
            text_mem[n_steps[STEP_W-1:0]][pend_len] = it.data_byte;
            pend_len = pend_len + 1'b1;
          end
          if (it.end_of_step) begin
            text_len[n_steps[STEP_W-1:0]]  = pend_len;
            delay_mem[n_steps[STEP_W-1:0]] = it.pause_ms;
            n_steps  = n_steps + 1'b1;
            pend_len = '0;
          end
          push_answer(ST_ACCEPTED, 8'h00, 1'b0, 1'b1);
        end
      end
      MODE_START: begin
        if (n_steps == 0) begin
          push_answer(ST_REJECTED, 8'h00, 1'b0, 1'b1);
        end else begin
          cursor  = '0;
          loop_on = it.loop_enable;
          playing = 1'b1;
          due_ms  = it.now_ms;
          push_answer(ST_ACCEPTED, 8'h00, 1'b0, 1'b1);
        end
      end
      MODE_TICK: begin
        if (!playing || cursor >= n_steps) begin
          push_answer(ST_REJECTED, 8'h00, 1'b0, 1'b1);
        end else if (it.now_ms < due_ms) begin
          push_answer(ST_WAITING, 8'h00, 1'b0, 1'b1);
        end else begin
          cur    = cursor[STEP_W-1:0];
          len    = text_len[cur];
          cursor = cursor + 1'b1;
          // schedule the next step; a wrap reuses the delay of the last one
          if (cursor >= n_steps) begin
            if (loop_on) begin
              cursor = '0;
              due_ms = it.now_ms + TIME_W'(delay_mem[cur]);
            end else begin
              playing = 1'b0;
            end
          end else begin
            due_ms = it.now_ms + TIME_W'(delay_mem[cursor[STEP_W-1:0]]);
          end
          if (len == 0) begin
            push_answer(ST_EMIT, 8'h00, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < int'(len); i++)
              push_answer(ST_EMIT, text_mem[cur][i], 1'b1, i == int'(len) - 1);
          end
        end
      end
      MODE_STOP: begin
        playing = 1'b0;
        push_answer(ST_ACCEPTED, 8'h00, 1'b0, 1'b1);
      end
      default: begin
        push_answer(ST_REJECTED, 8'h00, 1'b0, 1'b1);
      end
    endcase
  endtask

  task automatic check_beat(input out_item_t got);
    out_item_t want;
    if (answer_q.size() == 0) begin
      report_mismatch("unexpected result beat", 64'(got), '0);
      return;
    end
    want = answer_q.pop_front();
    if (got.status !== want.status)
      report_mismatch("status", 64'(got.status), 64'(want.status));
    if (got.out_byte !== want.out_byte)
      report_mismatch("out_byte", 64'(got.out_byte), 64'(want.out_byte));
    if (got.byte_valid !== want.byte_valid)
      report_mismatch("byte_valid", 64'(got.byte_valid), 64'(want.byte_valid));
    if (got.last !== want.last)
      report_mismatch("last", 64'(got.last), 64'(want.last));
    if (got.playing !== want.playing)
      report_mismatch("playing", 64'(got.playing), 64'(want.playing));
    if (got.step_count !== want.step_count)
      report_mismatch("step_count", 64'(got.step_count), 64'(want.step_count));
  endtask

  // Compare the strobed beat first: it always belongs to an older command
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_table();
      answer_q.delete();
      fail_count = 0;
      open_count <= 0;
    end else begin
      if (out_strobe === 1'b1)
        check_beat(out_item);
      if (start && !busy)
        run_command(in_item);
      open_count <= answer_q.size();
    end
  end

endmodule

/* tb/sv/timed_step_playback_tb.sv */
// ----------------------------------------------------------------------------
// timed_step_playback_tb: stimulus and verdict for timed_step_playback
// Drives directed commands over the corner cases (empty and long steps, full
// table, early ticks, time wrap, looping), then random record and playback
// sequences under three sender idling profiles; a checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_step_playback_tb;
  import tsp_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          in_item;
  logic              out_strobe;
  out_item_t         out_item;
  int                fail_count;
  int                open_count;
  int                beats_sent;
  int                gap_pct;
  logic [TIME_W-1:0] clock_ms;

  timed_step_playback dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  timed_step_playback_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up if the run hangs
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Random fill for every field; callers override what matters
  function automatic in_item_t any_item();
    in_item_t it;
    it.mode        = 3'($urandom);
    it.data_byte   = 8'($urandom);
    it.end_of_step = 1'($urandom);
    it.pause_ms    = 16'($urandom);
    it.loop_enable = 1'($urandom);
    it.now_ms      = {16'($urandom), $urandom};
    return it;
  endfunction

  // Present one beat at the falling edge, hold until taken
  task automatic send_beat(input in_item_t item);
    // idle each offered cycle with the current gap percentage
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic do_record(input logic [7:0] b, input logic eos,
                           input logic [DELAY_W-1:0] wait_ms);
    in_item_t it;
    it             = any_item();
    it.mode        = MODE_RECORD;
    it.data_byte   = b;
    it.end_of_step = eos;
    it.pause_ms    = wait_ms;
    send_beat(it);
  endtask

  task automatic do_start(input logic loop_en, input logic [TIME_W-1:0] now);
    in_item_t it;
    it             = any_item();
    it.mode        = MODE_START;
    it.loop_enable = loop_en;
    it.now_ms      = now;
    send_beat(it);
  endtask

  task automatic do_tick(input logic [TIME_W-1:0] now);
    in_item_t it;
    it        = any_item();
    it.mode   = MODE_TICK;
    it.now_ms = now;
    send_beat(it);
  endtask

  task automatic do_simple(input mode_t m);
    in_item_t it;
    it      = any_item();
    it.mode = m;
    send_beat(it);
  endtask

  // Modes above stop are undefined
  task automatic do_unused(input int k);
    in_item_t it;
    it      = any_item();
    it.mode = 3'(MODE_STOP) + 3'(k);
    send_beat(it);
  endtask

  // One step of random text; some bytes are zero
  task automatic record_step(input int n_bytes, input logic [DELAY_W-1:0] wait_ms);
    logic [7:0] b;
    for (int i = 0; i < n_bytes; i++) begin
      b = ($urandom_range(99) < 12) ? 8'h00 : 8'($urandom);
      do_record(b, i == n_bytes - 1, wait_ms);
    end
  endtask

  // Mostly short waits so ticks catch up, now and then a long one
  function automatic logic [DELAY_W-1:0] pick_delay();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return DELAY_W'($urandom_range(0, 8));
    if (roll < 90) return DELAY_W'($urandom_range(0, 200));
    return DELAY_W'($urandom);
  endfunction

  task automatic play_ticks(input int n);
    repeat (n) begin
      clock_ms = clock_ms + TIME_W'($urandom_range(0, 6));
      do_tick(clock_ms);
    end
  endtask

  task automatic run_random(input int count);
    int stop_at;
    int roll;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 38) begin
        record_step($urandom_range(1, 7), pick_delay());
      end else if (roll < 58) begin
        do_start(1'($urandom), clock_ms);
        play_ticks($urandom_range(1, 6));
      end else if (roll < 76) begin
        play_ticks($urandom_range(1, 4));
      end else if (roll < 82) begin
        do_simple(MODE_STOP);
      end else if (roll < 85) begin
        do_simple(MODE_CLEAR);
      end else if (roll < 91) begin
        send_beat(any_item());
      end else if (roll < 95) begin
        // broken step: a byte with no end of step
        do_record(8'($urandom), 1'b0, 16'($urandom));
      end else begin
        // jump the clock: far ahead, anywhere, or near the wrap point
        case ($urandom_range(2))
          0:       clock_ms = clock_ms + TIME_W'($urandom_range(0, 70000));
          1:       clock_ms = {16'($urandom), $urandom};
          default: clock_ms = '1 - TIME_W'($urandom_range(0, 40));
        endcase
      end
    end
  endtask

  // A step longer than the text limit, followed by a short one
  task automatic long_step_case();
    do_simple(MODE_CLEAR);
    record_step(STEP_TEXT + 2, DELAY_W'($urandom_range(0, 4)));
    record_step(1, DELAY_W'($urandom_range(0, 4)));
    do_start(1'($urandom), clock_ms);
    play_ticks(2);
  endtask

  // Fill every step, then push against the full table
  task automatic fill_table_case();
    do_simple(MODE_CLEAR);
    repeat (STEPS) record_step(1, DELAY_W'($urandom_range(0, 3)));
    do_record(8'($urandom), 1'b1, 16'($urandom));
    do_record(8'($urandom), 1'b0, 16'($urandom));
    do_start(1'b1, clock_ms);
    play_ticks(4);
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    clock_ms   = '0;
    beats_sent = 0;
    gap_pct    = 13;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Idle table: tick, start and undefined modes are refused, stop is harmless
    do_tick('0);
    do_start(1'b1, '0);
    do_simple(MODE_STOP);
    for (int k = 1; k <= 3; k++) do_unused(k);

    // Empty step, a step with a zero byte and the longest wait, a plain step
    do_record(8'h00, 1'b1, 16'h0000);
    do_record(8'hFF, 1'b0, 16'h0000);
    do_record(8'h01, 1'b0, 16'h1234);
    do_record(8'h00, 1'b0, 16'h0000);
    do_record(8'h80, 1'b1, 16'hFFFF);
    do_record(8'h55, 1'b1, 16'h0000);

    // Loop from the top of the time range: due time wraps, early tick waits
    do_start(1'b1, '1);
    do_tick('1);
    do_tick('0);
    do_tick(48'd65534);
    do_tick(48'd65534);
    do_tick(48'd65600);
    do_simple(MODE_STOP);
    do_tick(48'd65600);

    // Single pass, ending when the last step is played
    do_start(1'b0, 48'd5);
    do_tick(48'd5);
    do_tick(48'd65540);
    do_tick(48'd65540);
    do_tick(48'd65540);
    do_simple(MODE_CLEAR);

    clock_ms = '0;
    run_random(10);
    long_step_case();

    gap_pct = 60;
    run_random(10);
    fill_table_case();

    gap_pct = 0;
    run_random(10);

    // Drain outstanding results, then watch for strays
    start <= 1'b0;
    for (int n = 0; n < 10000 && open_count != 0; n++) @(negedge clk);
    repeat (80) @(negedge clk);
    if (open_count != 0)
      $display("%0d result beats never arrived", open_count);
    if (fail_count == 0 && open_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* timed_step_playback.f */
rtl/tsp_pkg.sv
rtl/tsp_ctrl.sv
rtl/tsp_datapath.sv
rtl/timed_step_playback.sv
tb/sv/timed_step_playback_checker.sv
tb/sv/timed_step_playback_tb.sv
